// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/pcc_pkg.sv =====
`default_nettype none

package pcc_pkg;

  // Default coordinate width taken from each 32-bit field
  localparam int COORD_WIDTH_DEF = 32;

  // Stream widths: two 32-bit coordinates in, three flag bits padded to a byte out
  localparam int TDATA_IN_W  = 64;
  localparam int TDATA_OUT_W = 8;

  // Turns judged per vertex: the running turn plus the two closing turns
  localparam int NUM_LANES = 3;

  // Lane roles
  localparam int LANE_RUN    = 0;
  localparam int LANE_CLOSE1 = 1;
  localparam int LANE_CLOSE2 = 2;

  // Control that travels alongside the data through the pipeline
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [NUM_LANES-1:0] turn_valid;
  } pcc_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/pcc_vertex_track.sv =====
`default_nettype none

// Keeps first, second and the two most recent vertices, and forms the
// edge vectors of every turn the incoming vertex completes.
module pcc_vertex_track #(
  parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [31:0]           vertex_x,
  input  wire logic [31:0]           vertex_y,
  input  wire logic                  last_vertex,
  output pcc_pkg::pcc_ctrl_t         ctrl_r,
  output logic signed [COORD_WIDTH:0] e1x_r [pcc_pkg::NUM_LANES],
  output logic signed [COORD_WIDTH:0] e1y_r [pcc_pkg::NUM_LANES],
  output logic signed [COORD_WIDTH:0] e2x_r [pcc_pkg::NUM_LANES],
  output logic signed [COORD_WIDTH:0] e2y_r [pcc_pkg::NUM_LANES]
);
  import pcc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;

  logic              accept;
  logic [CW-1:0]     vx, vy;
  logic [CW-1:0]     fx_r, fy_r, sx_r, sy_r, ox_r, oy_r, nx_r, ny_r;
  logic [1:0]        cnt_r, cnt_nxt;
  pcc_ctrl_t         ctrl_nxt;

  // Turn corners per lane: origin, apex, end
  logic [CW-1:0]     o_x [NUM_LANES];
  logic [CW-1:0]     o_y [NUM_LANES];
  logic [CW-1:0]     a_x [NUM_LANES];
  logic [CW-1:0]     a_y [NUM_LANES];
  logic [CW-1:0]     b_x [NUM_LANES];
  logic [CW-1:0]     b_y [NUM_LANES];

  // Exact difference of two signed coordinates, one bit wider
  function automatic logic [DW-1:0] diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    diff = {a[CW-1], a} - {b[CW-1], b};
  endfunction

  assign accept = in_valid && en;
  assign vx     = vertex_x[CW-1:0];
  assign vy     = vertex_y[CW-1:0];

  // Running turn: older -> newer -> incoming
  assign o_x[LANE_RUN] = ox_r;  assign o_y[LANE_RUN] = oy_r;
  assign a_x[LANE_RUN] = nx_r;  assign a_y[LANE_RUN] = ny_r;
  assign b_x[LANE_RUN] = vx;    assign b_y[LANE_RUN] = vy;
  // First closing turn: newer -> incoming -> first
  assign o_x[LANE_CLOSE1] = nx_r;  assign o_y[LANE_CLOSE1] = ny_r;
  assign a_x[LANE_CLOSE1] = vx;    assign a_y[LANE_CLOSE1] = vy;
  assign b_x[LANE_CLOSE1] = fx_r;  assign b_y[LANE_CLOSE1] = fy_r;
  // Second closing turn: incoming -> first -> second
  assign o_x[LANE_CLOSE2] = vx;    assign o_y[LANE_CLOSE2] = vy;
  assign a_x[LANE_CLOSE2] = fx_r;  assign a_y[LANE_CLOSE2] = fy_r;
  assign b_x[LANE_CLOSE2] = sx_r;  assign b_y[LANE_CLOSE2] = sy_r;

  // Vertex count and which turns this item completes
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (last_vertex) begin
        cnt_nxt = 2'd0;
      end else if (cnt_r != 2'd3) begin
        cnt_nxt = cnt_r + 2'd1;
      end
    end
    ctrl_nxt.valid                   = accept;
    ctrl_nxt.last                    = last_vertex;
    ctrl_nxt.turn_valid[LANE_RUN]    = cnt_r[1];
    ctrl_nxt.turn_valid[LANE_CLOSE1] = cnt_r[1] && last_vertex;
    ctrl_nxt.turn_valid[LANE_CLOSE2] = cnt_r[1] && last_vertex;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      ctrl_r <= '0;
    end else if (en) begin
      cnt_r  <= cnt_nxt;
      ctrl_r <= ctrl_nxt;
    end
  end

  // Stored vertices
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cnt_r == 2'd0) begin
        fx_r <= vx;
        fy_r <= vy;
      end
      if (cnt_r == 2'd1) begin
        sx_r <= vx;
        sy_r <= vy;
      end
      ox_r <= (cnt_r == 2'd0) ? vx : nx_r;
      oy_r <= (cnt_r == 2'd0) ? vy : ny_r;
      nx_r <= vx;
      ny_r <= vy;
    end
  end

  // Edge vectors per lane
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        e1x_r[i] <= diff(a_x[i], o_x[i]);
        e1y_r[i] <= diff(a_y[i], o_y[i]);
        e2x_r[i] <= diff(b_x[i], a_x[i]);
        e2y_r[i] <= diff(b_y[i], a_y[i]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcc_turn_lane.sv =====
`default_nettype none

// One turn: registered cross-product terms, then their compare.
module pcc_turn_lane #(
  parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [COORD_WIDTH:0] e1x,
  input  wire logic signed [COORD_WIDTH:0] e1y,
  input  wire logic signed [COORD_WIDTH:0] e2x,
  input  wire logic signed [COORD_WIDTH:0] e2y,
  output logic                        left,
  output logic                        right
);
  import pcc_pkg::*;

  localparam int PW = 2 * (COORD_WIDTH + 1);

  logic signed [PW-1:0] p_r, q_r;

  // Both terms of e1 x e2, full width so nothing overflows
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= e1x * e2y;
      q_r <= e1y * e2x;
    end
  end

  // Sign of p - q: positive is a left turn, negative a right turn
  assign left  = p_r > q_r;
  assign right = p_r < q_r;

endmodule

`default_nettype wire

// ===== rtl/polygon_convexity_check_core.sv =====
`default_nettype none

// Channel | Ports             | Payload
// --------+-------------------+-----------------------------------------------
// input   | in_t{valid,ready} | tdata: vertex_x [31:0], vertex_y [63:32];
//         | in_tdata, in_tlast| tlast: last_vertex
// result  | out_t{valid,ready}| tdata: is_convex [0], left_seen [1],
//         | out_tdata         | right_seen [2], zero [7:3]
//
// One vertex per cycle while in_tready is high; the last vertex passes the edge stage,
// the product stage, then the flag/result register before out_tvalid rises.
// The depth is set by the 33x33-bit cross-product multipliers, three lanes wide.
// rst_n is synchronous, active low; it clears counts, flags and valid bits,
// and in_tready is low while it is asserted.
// The pipeline holds only while a finished polygon waits behind a result that
// out_tready has not yet taken; in_tready is low for exactly those cycles and in reset.
module polygon_convexity_check_core #(
  parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [pcc_pkg::TDATA_IN_W-1:0]  in_tdata,  // vertex_x, vertex_y
  input  wire logic                            in_tlast,  // last_vertex
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [pcc_pkg::TDATA_OUT_W-1:0]      out_tdata  // is_convex, left_seen, right_seen
);
  import pcc_pkg::*;

  logic                      en, stall;
  pcc_ctrl_t                 ctrl1, ctrl2_r;
  logic signed [COORD_WIDTH:0] e1x [NUM_LANES];
  logic signed [COORD_WIDTH:0] e1y [NUM_LANES];
  logic signed [COORD_WIDTH:0] e2x [NUM_LANES];
  logic signed [COORD_WIDTH:0] e2y [NUM_LANES];
  logic [NUM_LANES-1:0]      lane_left, lane_right;
  logic                      left_r, right_r, left_all, right_all, done;
  logic                      out_tvalid_r;
  logic [TDATA_OUT_W-1:0]    out_tdata_r;

  // Pipeline holds only when a new result meets a result still waiting
  assign stall     = done && out_tvalid_r && !out_tready;
  assign en        = !stall;
  assign in_tready = en && rst_n;

  pcc_vertex_track #(.COORD_WIDTH(COORD_WIDTH)) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .vertex_x   (in_tdata[31:0]),
    .vertex_y   (in_tdata[63:32]),
    .last_vertex(in_tlast),
    .ctrl_r     (ctrl1),
    .e1x_r      (e1x),
    .e1y_r      (e1y),
    .e2x_r      (e2x),
    .e2y_r      (e2y)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pcc_turn_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
      .clk  (clk),
      .en   (en),
      .e1x  (e1x[g]),
      .e1y  (e1y[g]),
      .e2x  (e2x[g]),
      .e2y  (e2y[g]),
      .left (lane_left[g]),
      .right(lane_right[g])
    );
  end

  // Fold this item's turns into the polygon's flags
  assign left_all  = left_r  || (|(lane_left  & ctrl2_r.turn_valid));
  assign right_all = right_r || (|(lane_right & ctrl2_r.turn_valid));
  assign done      = ctrl2_r.valid && ctrl2_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl2_r      <= '0;
      left_r       <= 1'b0;
      right_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (en) begin
        ctrl2_r <= ctrl1;
        if (ctrl2_r.valid) begin
          left_r  <= left_all  && !ctrl2_r.last;
          right_r <= right_all && !ctrl2_r.last;
        end
      end
      // Result valid: set by a finished polygon, cleared once taken
      if (en && done) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (en && done) begin
      out_tdata_r <= {{(TDATA_OUT_W-3){1'b0}}, right_all, left_all,
                      !(left_all && right_all)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ===== rtl/pcc_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the convexity core
module pcc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [pcc_pkg::TDATA_OUT_W-1:0] out_tdata
);
  import pcc_pkg::*;

  // A stalled result stays offered and unchanged
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // Input is back-pressured only while a result is stalled
  `ASSERT_IMP(a_in_stall, clk, rst_n, !in_tready, out_tvalid && !out_tready)

  // Verdict agrees with the two turn flags
  `ASSERT_IMP(a_verdict, clk, rst_n, out_tvalid, out_tdata[0] == !(out_tdata[1] && out_tdata[2]))

  // Padding bits are zero
  `ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[TDATA_OUT_W-1:3] == '0)

endmodule

bind polygon_convexity_check_core pcc_checker u_pcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import pcc_pkg::*;

  localparam int N_VERTICES     = 1550;
  localparam int IDLE_PCT       = 12;
  localparam int QUIET_FROM     = 600;
  localparam int QUIET_TO       = 1100;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RESET_CYCLES   = 9;

  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam logic [31:0] CNEG = 32'hffff_ffff;

  // Coordinate pick modes for random polygons
  localparam int PICK_FULL    = 0;
  localparam int PICK_SMALL   = 1;
  localparam int PICK_EXTREME = 2;

  typedef struct packed {
    logic convex;
    logic left;
    logic right;
  } turn_flags_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  // One vertex to send; typed rows carry their result as written
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    logic        typed;
    logic        w_convex;
    logic        w_left;
    logic        w_right;
  } vertex_row_t;

  // Directed polygons: x, y, last, typed, convex, left, right
  localparam vertex_row_t DIR_TAB [25] = '{
    // one-vertex polygon at a corner of the range
    '{CMAX,   CMIN,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    // two-vertex polygon
    '{CMAX,   CMAX,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMIN,   CMIN,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    // counter-clockwise square: left turns only
    '{32'd0,  32'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd10, 32'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd10, 32'd10, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd0,  32'd10, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    // clockwise triangle: right turns only
    '{32'd0,  32'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd0,  32'd10, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd10, 32'd0,  1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    // concave pentagon, left to the predictor
    '{32'd0,  32'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd10, 32'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd5,  32'd2,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd10, 32'd10, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd0,  32'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    // collinear points: no turn at all
    '{32'd0,  32'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd1,  32'd1,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'd2,  32'd2,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    // repeated point
    '{CNEG,   CNEG,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CNEG,   CNEG,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CNEG,   CNEG,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    // full-range square: widest products, left turns only
    '{CMIN,   CMIN,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMAX,   CMIN,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMAX,   CMAX,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMIN,   CMAX,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0}
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [TDATA_IN_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tready = 1'b0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [TDATA_OUT_W-1:0]  out_tdata;

  polygon_convexity_check_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // vertex_x, vertex_y
    .in_tlast   (in_tlast),   // last_vertex
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // is_convex, left_seen, right_seen
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vertex_row_t vertex_q[$];
  turn_flags_t flags_q[$];
  vertex_row_t cur_vertex;
  int          vertices_queued = 0;
  int          err_count       = 0;
  int          cycle_count     = 0;
  int          stall_cycles    = 0;

  // Convexity tracker state
  point_t      poly_first, poly_second, poly_older, poly_newer;
  logic [1:0]  poly_count;
  logic        saw_left, saw_right;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  task automatic clear_polygon();
    poly_first  = '0;
    poly_second = '0;
    poly_older  = '0;
    poly_newer  = '0;
    poly_count  = 2'd0;
    saw_left    = 1'b0;
    saw_right   = 1'b0;
  endtask

  // Sign of (a - o) x (b - a), computed wide enough to be exact
  function automatic int turn_dir(point_t o, point_t a, point_t b);
    logic signed [33:0] e1x, e1y, e2x, e2y;
    logic signed [67:0] area;
    e1x  = $signed({{2{a.x[31]}}, a.x}) - $signed({{2{o.x[31]}}, o.x});
    e1y  = $signed({{2{a.y[31]}}, a.y}) - $signed({{2{o.y[31]}}, o.y});
    e2x  = $signed({{2{b.x[31]}}, b.x}) - $signed({{2{a.x[31]}}, a.x});
    e2y  = $signed({{2{b.y[31]}}, b.y}) - $signed({{2{a.y[31]}}, a.y});
    area = e1x * e2y - e1y * e2x;
    if (area > 0) return 1;
    if (area < 0) return -1;
    return 0;
  endfunction

  task automatic note_turn(input point_t o, input point_t a, input point_t b);
    int d;
    d = turn_dir(o, a, b);
    if (d > 0) saw_left = 1'b1;
    else if (d < 0) saw_right = 1'b1;
  endtask

  // Advance the tracker by one vertex; a last vertex closes the polygon
  task automatic convexity_step(input point_t v, input logic last,
                                output logic got, output turn_flags_t res);
    got = 1'b0;
    res = '0;
    case (poly_count)
      2'd0: begin
        poly_first = v;
        poly_older = v;
        poly_newer = v;
        poly_count = 2'd1;
      end
      2'd1: begin
        poly_second = v;
        poly_older  = poly_newer;
        poly_newer  = v;
        poly_count  = 2'd2;
      end
      default: begin
        note_turn(poly_older, poly_newer, v);
        poly_older = poly_newer;
        poly_newer = v;
        poly_count = 2'd3;
      end
    endcase
    if (last) begin
      if (poly_count == 2'd3) begin
        note_turn(poly_older, poly_newer, poly_first);
        note_turn(poly_newer, poly_first, poly_second);
      end
      got        = 1'b1;
      res.convex = !(saw_left && saw_right);
      res.left   = saw_left;
      res.right  = saw_right;
      clear_polygon();
    end
  endtask

  task automatic push_vertex(input logic [31:0] x, input logic [31:0] y, input logic last);
    vertex_row_t r;
    r       = '0;
    r.x     = x;
    r.y     = y;
    r.last  = last;
    vertex_q.push_back(r);
    vertices_queued++;
  endtask

  function automatic logic [31:0] pick_coord(int mode);
    if (mode == PICK_FULL) return $urandom();
    if (mode == PICK_SMALL) return $urandom_range(0, 8) - 32'd4;
    case ($urandom_range(0, 5))
      0: return CMIN;
      1: return CMAX;
      2: return 32'd0;
      3: return 32'd1;
      4: return CNEG;
      default: return CMIN + 32'd1;
    endcase
  endfunction

  // Convex polygons on a parabola in 40 percent of picks, the rest random or degenerate
  task automatic add_polygon();
    int          kind, n, x0, stp, xv, yv, mode;
    logic [31:0] offx, offy, px, py, tmp;
    bit          flip, swap;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      n    = $urandom_range(3, 10);
      x0   = int'($urandom_range(0, 30)) - 30;
      stp  = $urandom_range(1, 6);
      flip = 1'($urandom_range(0, 1));
      swap = 1'($urandom_range(0, 1));
      offx = $urandom_range(0, 1) ? $urandom() : 32'd0;
      offy = $urandom_range(0, 1) ? $urandom() : 32'd0;
      for (int i = 0; i < n; i++) begin
        xv = x0 + i * stp;
        yv = xv * xv;
        if (flip) yv = -yv;
        px = xv + offx;
        py = yv + offy;
        if (swap) begin
          tmp = px;
          px  = py;
          py  = tmp;
        end
        push_vertex(px, py, i == n - 1);
      end
    end else begin
      mode = (kind < 65) ? PICK_FULL : (kind < 85) ? PICK_SMALL : PICK_EXTREME;
      n    = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        push_vertex(pick_coord(mode), pick_coord(mode), i == n - 1);
    end
  endtask

  // Stream traffic: input acceptance and prediction, result checking, idling
  point_t      acc_point;
  logic        acc_got;
  turn_flags_t acc_flags;
  turn_flags_t want_flags;
  logic        quiet;

  always @(posedge clk) begin
    quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);
    cycle_count++;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      clear_polygon();
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;

      // Input item taken: predict its result
      if (in_tvalid && in_tready) begin
        acc_point.x = in_tdata[31:0];
        acc_point.y = in_tdata[63:32];
        convexity_step(acc_point, in_tlast, acc_got, acc_flags);
        if (acc_got) begin
          if (cur_vertex.typed)
            flags_q.push_back({cur_vertex.w_convex, cur_vertex.w_left, cur_vertex.w_right});
          else
            flags_q.push_back(acc_flags);
        end
      end

      // Result item taken: compare with the oldest expectation
      if (out_tvalid && out_tready) begin
        if (flags_q.size() == 0) begin
          report_mismatch("unexpected result, tdata", out_tdata, 0);
        end else begin
          want_flags = flags_q.pop_front();
          if (out_tdata[0] !== want_flags.convex)
            report_mismatch("is_convex", out_tdata[0], want_flags.convex);
          if (out_tdata[1] !== want_flags.left)
            report_mismatch("left_seen", out_tdata[1], want_flags.left);
          if (out_tdata[2] !== want_flags.right)
            report_mismatch("right_seen", out_tdata[2], want_flags.right);
        end
      end

      // Next input item, with random gaps
      if (!in_tvalid || in_tready) begin
        if (vertex_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_vertex = vertex_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_vertex.y, cur_vertex.x};
          in_tlast  <= cur_vertex.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
    out_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: too long without any item moving
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    foreach (DIR_TAB[i]) vertex_q.push_back(DIR_TAB[i]);
    while (vertices_queued < N_VERTICES) add_polygon();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (vertex_q.size() != 0 || in_tvalid || flags_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pcc_pkg.sv
rtl/pcc_vertex_track.sv
rtl/pcc_turn_lane.sv
rtl/polygon_convexity_check_core.sv
rtl/pcc_checker.sv
tb/tb.sv
